// File: hw/rtl/utg_pkg.sv
// ----------------------------------------------------------------------------
// utg_pkg
// Shared types, constants and glyph mapping functions for the UTF-8 to glyph
// slot decoder.
// ----------------------------------------------------------------------------
package utg_pkg;

   // String buffer size; at most BUFFER_BYTES-1 characters per string
   localparam int BUFFER_BYTES = 256;
   localparam int CHARS_W      = $clog2(BUFFER_BYTES);
   localparam logic [CHARS_W-1:0] CHAR_LIMIT = CHARS_W'(BUFFER_BYTES - 1);

   // Decode phase codes
   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LEAD2  = 2'd1;
   localparam logic [1:0] PH_LEAD3  = 2'd2;
   localparam logic [1:0] PH_LEAD3B = 2'd3;

   // Lead byte classes
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;

   localparam logic [15:0] CP_QMARK  = 16'd63;
   localparam logic [7:0]  GL_QMARK  = 8'd63;
   localparam logic [6:0]  SLOT_QMARK = 7'd31;

   typedef struct packed {
      logic [15:0] code_point;
      logic [7:0]  glyph_code;
      logic [6:0]  font_slot;
      logic        end_of_text;
   } res_type;

   // Up to three results caused by one text byte
   typedef struct packed {
      logic [1:0]        count;
      res_type [2:0]     ent;
   } bundle_type;

   function automatic logic [7:0] glyph_for(input logic [15:0] cp);
      logic [7:0] g;
      case (cp)
         16'h00E4: g = 8'd225;
         16'h00F6: g = 8'd243;
         16'h00FC: g = 8'd252;
         16'h00C4: g = 8'd193;
         16'h00D6: g = 8'd211;
         16'h00DC: g = 8'd218;
         16'h00DF: g = 8'd239;
         16'h201C, 16'h201D, 16'h201E: g = 8'h22;
         16'h2018, 16'h2019: g = 8'h27;
         16'h2013, 16'h2014: g = 8'h2D;
         16'h000A: g = 8'h0A;
         default: g = (cp >= 16'd32 && cp < 16'd127) ? cp[7:0] : GL_QMARK;
      endcase
      return g;
   endfunction

   function automatic logic [6:0] slot_for(input logic [7:0] g);
      logic [6:0] s;
      logic [7:0] d;
      d = g - 8'd32;
      case (g)
         8'd225: s = 7'd105;
         8'd243: s = 7'd108;
         8'd252: s = 7'd111;
         8'd193: s = 7'd100;
         8'd211: s = 7'd103;
         8'd218: s = 7'd104;
         8'd239: s = 7'd110;
         default: s = (g >= 8'd32 && g < 8'd128) ? d[6:0] : SLOT_QMARK;
      endcase
      return s;
   endfunction

   function automatic res_type make_char(input logic [15:0] cp);
      res_type r;
      r.code_point  = cp;
      r.glyph_code  = glyph_for(cp);
      r.font_slot   = slot_for(r.glyph_code);
      r.end_of_text = 1'b0;
      return r;
   endfunction

   function automatic res_type make_end();
      res_type r;
      r = '0;
      r.end_of_text = 1'b1;
      return r;
   endfunction

endpackage

// File: hw/rtl/utg_if.sv
// ----------------------------------------------------------------------------
// utg interfaces
// Valid/ready channels for text bytes in and glyph results out.
// ----------------------------------------------------------------------------
interface utg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface utg_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_point;
   logic [7:0]  glyph_code;
   logic [6:0]  font_slot;
   logic        end_of_text;
   logic        last_result;

   modport source (output valid, output code_point, output glyph_code,
                   output font_slot, output end_of_text, output last_result,
                   input ready);
   modport sink   (input valid, input code_point, input glyph_code,
                   input font_slot, input end_of_text, input last_result,
                   output ready);
endinterface

// File: hw/rtl/utg_decode.sv
// ----------------------------------------------------------------------------
// utg_decode
// UTF-8 sequence state and per-byte decode into a bundle of results.
// ----------------------------------------------------------------------------
module utg_decode import utg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] text_byte,
   output bundle_type bundle
);

   logic [1:0]         phase_ff,  phase_in;
   logic [7:0]         lead_ff,   lead_in;
   logic [7:0]         second_ff, second_in;
   logic [CHARS_W-1:0] chars_ff,  chars_in;

   logic room0, room1, cut1, cut2;
   logic [15:0] cp2, cp3, cp_second;

   assign room0 = chars_ff < CHAR_LIMIT;
   assign room1 = ({1'b0, chars_ff} + (CHARS_W+1)'(1)) < {1'b0, CHAR_LIMIT};
   assign cut1  = (phase_ff != PH_IDLE) && room0;
   assign cut2  = (phase_ff == PH_LEAD3B) && room1;

   assign cp2       = {5'b0, lead_ff[4:0], text_byte[5:0]};
   assign cp3       = {lead_ff[3:0], second_ff[5:0], text_byte[5:0]};
   assign cp_second = second_ff[7] ? CP_QMARK : {8'h00, second_ff};

   // Decode the byte against the held sequence
   always_comb begin
      bundle    = '0;
      phase_in  = phase_ff;
      lead_in   = lead_ff;
      second_in = second_ff;
      chars_in  = chars_ff;
      if (text_byte == 8'h00) begin
         // End of string: flush a cut sequence, then the end marker
         if (cut2) begin
            bundle.count  = 2'd3;
            bundle.ent[0] = make_char(CP_QMARK);
            bundle.ent[1] = make_char(cp_second);
            bundle.ent[2] = make_end();
         end else if (cut1) begin
            bundle.count  = 2'd2;
            bundle.ent[0] = make_char(CP_QMARK);
            bundle.ent[1] = make_end();
         end else begin
            bundle.count  = 2'd1;
            bundle.ent[0] = make_end();
         end
         phase_in  = PH_IDLE;
         lead_in   = '0;
         second_in = '0;
         chars_in  = '0;
      end else begin
         unique case (phase_ff)
            PH_LEAD2: begin
               bundle.count  = 2'd1;
               bundle.ent[0] = make_char(cp2);
               phase_in      = PH_IDLE;
            end
            PH_LEAD3: begin
               second_in = text_byte;
               phase_in  = PH_LEAD3B;
            end
            PH_LEAD3B: begin
               bundle.count  = 2'd1;
               bundle.ent[0] = make_char(cp3);
               phase_in      = PH_IDLE;
            end
            default: begin
               if (room0) begin
                  if (!text_byte[7]) begin
                     bundle.count  = 2'd1;
                     bundle.ent[0] = make_char({8'h00, text_byte});
                  end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
                     lead_in  = text_byte;
                     phase_in = PH_LEAD2;
                  end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
                     lead_in  = text_byte;
                     phase_in = PH_LEAD3;
                  end else begin
                     bundle.count  = 2'd1;
                     bundle.ent[0] = make_char(CP_QMARK);
                  end
               end
            end
         endcase
         chars_in = chars_ff + CHARS_W'(bundle.count);
      end
   end

   // Advance the sequence state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         lead_ff   <= '0;
         second_ff <= '0;
         chars_ff  <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         lead_ff   <= lead_in;
         second_ff <= second_in;
         chars_ff  <= chars_in;
      end
   end

endmodule

// File: hw/rtl/utg_emit.sv
// ----------------------------------------------------------------------------
// utg_emit
// Result register: holds one bundle and hands its results out in order.
// ----------------------------------------------------------------------------
module utg_emit import utg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load_valid,
   output logic       load_ready,
   input  bundle_type bundle,
   utg_rsp_if.source  rsp
);

   logic [1:0]    count_ff, count_in;
   logic [1:0]    idx_ff,   idx_in;
   res_type [2:0] ent_ff,   ent_in;
   logic          busy, last;
   res_type       cur;

   assign busy       = count_ff != 2'd0;
   assign last       = idx_ff == (count_ff - 2'd1);
   assign load_ready = !busy || (rsp.ready && last);

   assign cur             = ent_ff[idx_ff];
   assign rsp.valid       = busy;
   assign rsp.code_point  = cur.code_point;
   assign rsp.glyph_code  = cur.glyph_code;
   assign rsp.font_slot   = cur.font_slot;
   assign rsp.end_of_text = cur.end_of_text;
   assign rsp.last_result = last;

   // Load a new bundle or step to the next result
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      ent_in   = ent_ff;
      if (load_valid && load_ready) begin
         count_in = bundle.count;
         idx_in   = 2'd0;
         ent_in   = bundle.ent;
      end else if (busy && rsp.ready) begin
         // drop the bundle once its last result is taken
         if (last) begin
            count_in = 2'd0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
      ent_ff <= ent_in;
   end

endmodule

// File: hw/rtl/utg_to_glyph_slot.sv
// ----------------------------------------------------------------------------
// utf8_to_glyph_slot
// Streaming UTF-8 to Latin-1 glyph and font slot decoder.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one text byte per transfer; a zero byte ends the string.
//   rsp_chan carries glyph results: code point, Latin-1 glyph, font slot,
//   an end-of-text flag and a flag on the last result of each input byte.
//   A byte that completes a character gives one result in the cycle after its
//   transfer; lead bytes give none. A zero byte gives the end marker,
//   preceded by up to two results for a cut sequence, one per cycle while
//   the receiver is ready. Throughput is one byte per cycle while each
//   byte gives at most one result and the receiver is ready; a zero byte
//   with a cut sequence holds the single result register until drained.
//   At most BUFFER_BYTES-1 characters are produced per string.
//   Reset (synchronous) clears the sequence state and the character count
//   and empties the result register; no clearing pass is needed.
//   When the receiver stalls, the current result holds and req_chan.ready
//   stays low until the last held result is taken; it rises again in the
//   cycle that transfer completes.
// ----------------------------------------------------------------------------
module utf8_to_glyph_slot import utg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   utg_req_if.sink   req_chan,
   utg_rsp_if.source rsp_chan
);

   bundle_type bundle;
   logic       take;

   assign take = req_chan.valid && req_chan.ready;

   // Decode the incoming byte
   utg_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .text_byte (req_chan.text_byte),
      .bundle    (bundle)
   );

   // Hold and hand out results
   utg_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_chan.valid),
      .load_ready (req_chan.ready),
      .bundle     (bundle),
      .rsp        (rsp_chan)
   );

   // The end marker always closes the results of its byte
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_text |-> rsp_chan.last_result)
      else $error("end marker not flagged as last result");

   // The end marker carries no character
   a_end_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.end_of_text |->
         rsp_chan.code_point == 16'd0 && rsp_chan.glyph_code == 8'd0)
      else $error("end marker carries a character");

   // No new byte while earlier results of a byte are still pending
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last_result |-> !req_chan.ready)
      else $error("input taken while results pending");

   // Font slots stay inside the font
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.font_slot <= 7'd111)
      else $error("font slot out of range");

endmodule

// File: test/glyph_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// glyph_checker
// Watches the text byte and glyph result channels of the UTF-8 decoder,
// predicts the glyph results of every accepted byte and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_checker import utg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_text_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_code_point,
   input  logic [7:0]  rsp_glyph_code,
   input  logic [6:0]  rsp_font_slot,
   input  logic        rsp_end_of_text,
   input  logic        rsp_last_result,
   output int          fail_count,
   output int          glyphs_due
);

   localparam int CHAR_CAP = BUFFER_BYTES - 1;

   typedef struct packed {
      logic [15:0] code_point;
      logic [7:0]  glyph_code;
      logic [6:0]  font_slot;
      logic        end_of_text;
      logic        last_result;
   } glyph_entry_type;

   glyph_entry_type expected_glyphs[$];
   glyph_entry_type byte_glyphs[$];

   // Decoder state as seen from outside
   logic [1:0] seq_phase;
   logic [7:0] seq_lead;
   logic [7:0] seq_second;
   int         char_count;
   int         mismatches = 0;

   assign fail_count = mismatches;

   function automatic logic [7:0] latin1_of(input logic [15:0] cp);
      case (cp)
         16'h00E4: return 8'd225;
         16'h00F6: return 8'd243;
         16'h00FC: return 8'd252;
         16'h00C4: return 8'd193;
         16'h00D6: return 8'd211;
         16'h00DC: return 8'd218;
         16'h00DF: return 8'd239;
         16'h201C, 16'h201D, 16'h201E: return 8'h22;
         16'h2018, 16'h2019: return 8'h27;
         16'h2013, 16'h2014: return 8'h2D;
         16'h000A: return 8'h0A;
         default: return (cp >= 16'd32 && cp < 16'd127) ? cp[7:0] : GL_QMARK;
      endcase
   endfunction

   function automatic logic [6:0] slot_of(input logic [7:0] g);
      case (g)
         8'd225: return 7'd105;
         8'd243: return 7'd108;
         8'd252: return 7'd111;
         8'd193: return 7'd100;
         8'd211: return 7'd103;
         8'd218: return 7'd104;
         8'd239: return 7'd110;
         default: return (g >= 8'd32 && g < 8'd128) ? 7'(g - 8'd32) : SLOT_QMARK;
      endcase
   endfunction

   function automatic bit has_room();
      return char_count < CHAR_CAP;
   endfunction

   // Stage one character for the current byte and count it
   function automatic void emit_char(input logic [15:0] cp);
      glyph_entry_type e;
      e.code_point  = cp;
      e.glyph_code  = latin1_of(cp);
      e.font_slot   = slot_of(e.glyph_code);
      e.end_of_text = 1'b0;
      e.last_result = 1'b0;
      byte_glyphs.push_back(e);
      char_count++;
   endfunction

   function automatic void clear_state();
      seq_phase  = PH_IDLE;
      seq_lead   = 8'h00;
      seq_second = 8'h00;
      char_count = 0;
   endfunction

   // Advance the decoder by one text byte and queue what it yields
   function automatic void decode_byte(input logic [7:0] b);
      glyph_entry_type marker;
      if (b == 8'h00) begin
         // cut sequence: '?' for the lead, then the held second byte if ASCII, else '?'
         if (seq_phase != PH_IDLE && has_room())
            emit_char(CP_QMARK);
         if (seq_phase == PH_LEAD3B && has_room())
            emit_char(seq_second < 8'h80 ? {8'h00, seq_second} : CP_QMARK);
         marker = '0;
         marker.end_of_text = 1'b1;
         byte_glyphs.push_back(marker);
         clear_state();
      end else begin
         case (seq_phase)
            PH_LEAD2: begin
               emit_char({5'd0, seq_lead[4:0], b[5:0]});
               seq_phase = PH_IDLE;
            end
            PH_LEAD3: begin
               seq_second = b;
               seq_phase  = PH_LEAD3B;
            end
            PH_LEAD3B: begin
               emit_char({seq_lead[3:0], seq_second[5:0], b[5:0]});
               seq_phase = PH_IDLE;
            end
            default: begin
               // new sequences only while below the character limit
               if (has_room()) begin
                  if (b < 8'h80) begin
                     emit_char({8'h00, b});
                  end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                     seq_lead  = b;
                     seq_phase = PH_LEAD2;
                  end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                     seq_lead  = b;
                     seq_phase = PH_LEAD3;
                  end else begin
                     emit_char(CP_QMARK);
                  end
               end
            end
         endcase
      end
      // flag the final result of this byte and move the batch over
      if (byte_glyphs.size() > 0)
         byte_glyphs[byte_glyphs.size() - 1].last_result = 1'b1;
      foreach (byte_glyphs[i])
         expected_glyphs.push_back(byte_glyphs[i]);
      byte_glyphs.delete();
   endfunction

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Predict on each byte transfer, compare on each result transfer
   always @(posedge clock) begin
      glyph_entry_type want;
      if (reset) begin
         expected_glyphs.delete();
         clear_state();
         glyphs_due <= 0;
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_text_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_glyphs.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual cp %h glyph %h",
                        $time, rsp_code_point, rsp_glyph_code);
               mismatches++;
            end else begin
               want = expected_glyphs.pop_front();
               check_field("code_point", 32'(want.code_point), 32'(rsp_code_point));
               check_field("glyph_code", 32'(want.glyph_code), 32'(rsp_glyph_code));
               check_field("font_slot", 32'(want.font_slot), 32'(rsp_font_slot));
               check_field("end_of_text", 32'(want.end_of_text), 32'(rsp_end_of_text));
               check_field("last_result", 32'(want.last_result), 32'(rsp_last_result));
            end
         end
         glyphs_due <= expected_glyphs.size();
      end
   end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives text strings into the UTF-8 to glyph slot decoder: a directed set of
// characters and cut sequences, then random strings, mostly well formed, and
// one string that runs into the character limit. Both sides idle at random;
// the receiver also holds off for a long stretch. The checker does the rest.
// ----------------------------------------------------------------------------
module tb_top import utg_pkg::*; ();

   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int QUIET_ITEMS = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   utg_req_if req_if();
   utg_rsp_if rsp_if();

   int  fail_count;
   int  glyphs_due;
   bit  hold_flag = 1'b0;
   bit  hold_done = 1'b0;
   bit  quiet = 1'b0;
   int  hold_at;
   int  quiet_from;

   logic [7:0] text_stream[$];

   // Code points with their own glyph entries
   localparam logic [15:0] SPECIAL_CP [0:14] = '{
      16'h000A, 16'h00E4, 16'h00F6, 16'h00FC, 16'h00C4, 16'h00D6, 16'h00DC,
      16'h00DF, 16'h201C, 16'h201D, 16'h201E, 16'h2018, 16'h2019, 16'h2013,
      16'h2014
   };

   always #4 clock = ~clock;

   utf8_to_glyph_slot uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   glyph_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_text_byte   (req_if.text_byte),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_code_point  (rsp_if.code_point),
      .rsp_glyph_code  (rsp_if.glyph_code),
      .rsp_font_slot   (rsp_if.font_slot),
      .rsp_end_of_text (rsp_if.end_of_text),
      .rsp_last_result (rsp_if.last_result),
      .fail_count      (fail_count),
      .glyphs_due      (glyphs_due)
   );

   // Encode a code point as well-formed UTF-8 of one to three bytes
   function automatic void push_code_point(input logic [15:0] cp);
      if (cp < 16'h0080) begin
         text_stream.push_back(cp[7:0]);
      end else if (cp < 16'h0800) begin
         text_stream.push_back({3'b110, cp[10:6]});
         text_stream.push_back({2'b10, cp[5:0]});
      end else begin
         text_stream.push_back({4'b1110, cp[15:12]});
         text_stream.push_back({2'b10, cp[11:6]});
         text_stream.push_back({2'b10, cp[5:0]});
      end
   endfunction

   function automatic void push_random_char();
      int pick;
      logic [7:0] lead;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         text_stream.push_back(8'($urandom_range(1, 127)));
      end else if (pick < 50) begin
         push_code_point(SPECIAL_CP[$urandom_range(0, 14)]);
      end else if (pick < 62) begin
         push_code_point(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 74) begin
         push_code_point(16'($urandom_range(16'h0800, 16'hFFFF)));
      end else if (pick < 80) begin
         // overlong two-byte form
         text_stream.push_back(8'($urandom_range(8'hC0, 8'hC1)));
         text_stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (pick < 88) begin
         // lead byte followed by arbitrary nonzero bytes
         lead = 8'($urandom_range(8'hC0, 8'hEF));
         text_stream.push_back(lead);
         text_stream.push_back(8'($urandom_range(1, 255)));
         if (lead >= 8'hE0)
            text_stream.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 95) begin
         // invalid lead
         if ($urandom_range(0, 1))
            text_stream.push_back(8'($urandom_range(8'h80, 8'hBF)));
         else
            text_stream.push_back(8'($urandom_range(8'hF0, 8'hFF)));
      end else begin
         text_stream.push_back(8'($urandom_range(1, 255)));
      end
   endfunction

   // Append short random strings until the stream holds at least stop_len bytes
   function automatic void push_short_strings(input int stop_len);
      int n_chars;
      logic [7:0] lead;
      while (text_stream.size() < stop_len) begin
         n_chars = $urandom_range(0, 10);
         repeat (n_chars) push_random_char();
         if ($urandom_range(0, 99) < 20) begin
            // cut the string inside a sequence
            lead = 8'($urandom_range(8'hC0, 8'hEF));
            text_stream.push_back(lead);
            if (lead >= 8'hE0 && $urandom_range(0, 1))
               text_stream.push_back(8'($urandom_range(1, 255)));
         end
         text_stream.push_back(8'h00);
      end
   endfunction

   // Fill up to one below the limit, then either cut a sequence or overrun
   function automatic void push_limit_string(input bit overrun);
      repeat (CHAR_LIMIT - 1) text_stream.push_back(8'($urandom_range(1, 127)));
      if (overrun) begin
         push_code_point(16'($urandom_range(16'h0800, 16'hFFFF)));
         repeat (12) text_stream.push_back(8'($urandom_range(1, 255)));
         text_stream.push_back(8'hC3);
      end else begin
         text_stream.push_back(8'hE2);
         text_stream.push_back(8'($urandom_range(1, 255)));
      end
      text_stream.push_back(8'h00);
   endfunction

   function automatic void build_stream();
      int directed_len;
      // ASCII letter, newline, DEL
      text_stream.push_back(8'h41);
      text_stream.push_back(8'h0A);
      text_stream.push_back(8'h7F);
      // German letters, quote, highest three-byte code point
      push_code_point(16'h00E4);
      push_code_point(16'h00DF);
      push_code_point(16'h201C);
      push_code_point(16'hFFFF);
      // invalid leads
      text_stream.push_back(8'h80);
      text_stream.push_back(8'hFF);
      // overlong sequence decoding to zero
      text_stream.push_back(8'hC0);
      text_stream.push_back(8'h80);
      text_stream.push_back(8'h00);
      // cut two-byte lead
      text_stream.push_back(8'hC3);
      text_stream.push_back(8'h00);
      // cut three-byte sequence with ASCII and with high second byte
      text_stream.push_back(8'hE2);
      text_stream.push_back(8'h41);
      text_stream.push_back(8'h00);
      text_stream.push_back(8'hE2);
      text_stream.push_back(8'hC3);
      text_stream.push_back(8'h00);
      directed_len = text_stream.size();
      hold_at = directed_len + 40;
      push_short_strings(directed_len + 45);
      quiet_from = text_stream.size() + 100;
      push_limit_string(1'b1);
      push_short_strings(text_stream.size() + 10);
   endfunction

   // Offer one byte, idling at random first, and wait for its transfer
   task automatic send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(0, 99) < 26) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.text_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin : receiver
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_flag && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 26);
            @(posedge clock);
         end
      end
   end

   // End the run when nothing transfers for too long
   initial begin : watchdog
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("tb_top NOT OK");
      $finish;
   end

   initial begin : stimulus
      int idx;
      req_if.valid     <= 1'b0;
      req_if.text_byte <= 8'h00;
      build_stream();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (idx = 0; idx < text_stream.size(); idx++) begin
         if (idx == hold_at)
            hold_flag = 1'b1;
         quiet = (idx >= quiet_from && idx < quiet_from + QUIET_ITEMS);
         send_byte(text_stream[idx]);
      end
      quiet = 1'b0;
      req_if.valid <= 1'b0;
      // drain outstanding results, then allow the result register to settle
      @(posedge clock);
      while (glyphs_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
